// ----- hw/rtl/soalu_pkg.sv -----
// Package for the single-operand ALU: operation codes, flag bit positions
// and byte/word masks. No dependencies.
package soalu_pkg;

  typedef enum logic [3:0] {
    OP_CLR  = 4'd0,
    OP_COM  = 4'd1,
    OP_INC  = 4'd2,
    OP_DEC  = 4'd3,
    OP_NEG  = 4'd4,
    OP_ADC  = 4'd5,
    OP_SBC  = 4'd6,
    OP_TST  = 4'd7,
    OP_ROR  = 4'd8,
    OP_ROL  = 4'd9,
    OP_ASR  = 4'd10,
    OP_ASL  = 4'd11,
    OP_SWAB = 4'd12,
    OP_SXT  = 4'd13
  } op_e;

  localparam int unsigned FlagN = 3;
  localparam int unsigned FlagZ = 2;
  localparam int unsigned FlagV = 1;
  localparam int unsigned FlagC = 0;

  localparam logic [15:0] HiByteMask = 16'hFF00;
  localparam logic [15:0] LoByteMask = 16'h00FF;

endpackage

// ----- hw/rtl/single_operand_alu_with_flags.sv -----
// Single-operand ALU with N/Z/V/C condition codes, word or byte form.
// Data path: input register, then result register; done_o is high in the same cycle
// that the result register shows the word, both loaded from the input register.
// Throughput: one word per cycle; busy_o stays low and the result strobe cannot be held off.
// Reset: rst_ni asynchronous, active low, clears both valid flags only.
// Depends on soalu_pkg.
module single_operand_alu_with_flags
  import soalu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [3:0]  req_type_i,
  input  logic        byte_mode_i,
  input  logic [15:0] operand_i,
  input  logic [3:0]  flags_in_i,
  output logic        done_o,
  output logic [15:0] result_value_o,
  output logic        write_back_o,
  output logic [3:0]  flags_out_o
);

  logic        in_vld_q;
  op_e         op_q;
  logic        byte_q;
  logic [15:0] opnd_q;
  logic [3:0]  fin_q;

  logic        done_q;
  logic [15:0] result_q, result_d;
  logic        wb_q, wb_d;
  logic [3:0]  flags_q, flags_d;

  logic        byte_w;
  logic [15:0] mask, sign, maxpos, d, r;
  logic        cin, n, z, v, c;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= start_i;
      done_q   <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q   <= op_e'(req_type_i);
      byte_q <= byte_mode_i;
      opnd_q <= operand_i;
      fin_q  <= flags_in_i;
    end
    if (in_vld_q) begin
      result_q <= result_d;
      wb_q     <= wb_d;
      flags_q  <= flags_d;
    end
  end

  // swab and sxt always work on the full word
  assign byte_w = byte_q && (op_q != OP_SWAB) && (op_q != OP_SXT);
  assign mask   = byte_w ? LoByteMask : 16'hFFFF;
  assign sign   = byte_w ? 16'h0080 : 16'h8000;
  assign maxpos = sign - 16'd1;
  assign d      = opnd_q & mask;
  assign cin    = fin_q[FlagC];

  always_comb begin
    r        = d;
    n        = (r & sign) != 16'd0;
    z        = 1'b0;
    v        = 1'b0;
    c        = cin;
    wb_d     = 1'b1;
    result_d = 16'd0;
    flags_d  = 4'd0;
    unique case (op_q)
      OP_CLR: begin
        r = 16'd0;
        c = 1'b0;
      end
      OP_COM: begin
        r = ~d & mask;
        c = 1'b1;
      end
      OP_INC: begin
        v = (d == maxpos);
        r = (d + 16'd1) & mask;
      end
      OP_DEC: begin
        v = (d == sign);
        r = (d - 16'd1) & mask;
      end
      OP_NEG: begin
        r = (16'd0 - d) & mask;
        v = (r == sign);
        c = (r != 16'd0);
      end
      OP_ADC: begin
        if (cin) begin
          v = (d == maxpos);
          c = (d == mask);
          r = (d + 16'd1) & mask;
        end else begin
          c = 1'b0;
        end
      end
      OP_SBC: begin
        v = (d == sign);
        if (cin) begin
          c = (d == 16'd0);
          r = (d - 16'd1) & mask;
        end else begin
          c = 1'b0;
        end
      end
      OP_TST: begin
        c    = 1'b0;
        wb_d = 1'b0;
      end
      OP_ROR: begin
        r = (d >> 1) | (cin ? sign : 16'd0);
        c = d[0];
      end
      OP_ROL: begin
        r = ((d << 1) | {15'd0, cin}) & mask;
        c = (d & sign) != 16'd0;
      end
      OP_ASR: begin
        r = (d >> 1) | (d & sign);
        c = d[0];
      end
      OP_ASL: begin
        r = (d << 1) & mask;
        c = (d & sign) != 16'd0;
      end
      OP_SWAB: begin
        r = ((d << 8) & HiByteMask) | ((d >> 8) & LoByteMask);
        c = 1'b0;
      end
      OP_SXT: begin
        r = fin_q[FlagN] ? 16'hFFFF : 16'd0;
      end
      default: begin
        wb_d = 1'b0;
      end
    endcase

    // N and Z from the result, with the two word-only exceptions
    n = (r & sign) != 16'd0;
    z = (r == 16'd0);
    if (op_q == OP_SWAB) begin
      n = r[7];
      z = (r & LoByteMask) == 16'd0;
    end
    if (op_q == OP_SXT) begin
      n = fin_q[FlagN];
      z = !fin_q[FlagN];
    end
    if (op_q == OP_ROR || op_q == OP_ROL || op_q == OP_ASR || op_q == OP_ASL) begin
      v = n ^ c;
    end

    result_d            = r;
    flags_d[FlagN]      = n;
    flags_d[FlagZ]      = z;
    flags_d[FlagV]      = v;
    flags_d[FlagC]      = c;

    // unused codes pass the operand and flags through untouched, with no write-back
    if (op_q > OP_SXT) begin
      result_d = opnd_q;
      flags_d  = fin_q;
    end
  end

  assign done_o         = done_q;
  assign result_value_o = result_q;
  assign write_back_o   = wb_q;
  assign flags_out_o    = flags_q;

endmodule

// ----- hw/rtl/soalu_checker.sv -----
// Port-level checker for single_operand_alu_with_flags, attached by bind.
// Depends on soalu_pkg.
module soalu_props
  import soalu_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [3:0]  req_type_i,
  input logic        done_o,
  input logic [15:0] result_value_o,
  input logic        write_back_o,
  input logic [3:0]  flags_out_o
);

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without accepted word");

  a_tst_no_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(req_type_i, 2) == OP_TST) |->
      (!write_back_o && flags_out_o[FlagV] == 1'b0 && flags_out_o[FlagC] == 1'b0))
    else $error("test stored a result or set V/C");

  a_clr_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(req_type_i, 2) == OP_CLR) |->
      (result_value_o == 16'd0 && write_back_o && flags_out_o == 4'b0100))
    else $error("clear gave wrong result or flags");

endmodule

bind single_operand_alu_with_flags soalu_props u_soalu_props (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .req_type_i     (req_type_i),
  .done_o         (done_o),
  .result_value_o (result_value_o),
  .write_back_o   (write_back_o),
  .flags_out_o    (flags_out_o)
);

// ----- verif/soalu_checker.sv -----
// Checker for the single-operand ALU: predicts result words from accepted
// commands and compares each done_o strobe against the oldest prediction.
// Depends on soalu_pkg.
module soalu_checker
  import soalu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic [3:0]  req_type_i,
  input  logic        byte_mode_i,
  input  logic [15:0] operand_i,
  input  logic [3:0]  flags_in_i,
  input  logic        done_o,
  input  logic [15:0] result_value_o,
  input  logic        write_back_o,
  input  logic [3:0]  flags_out_o,
  output int          err_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] value;
    logic        wb;
    logic [3:0]  flags;
  } alu_word_t;

  alu_word_t predicted_q[$];
  alu_word_t want;
  int        mismatches = 0;

  function automatic alu_word_t predict_alu_word(logic [3:0] op, logic byte_sel,
                                                 logic [15:0] opnd, logic [3:0] cc);
    logic [15:0] mask, sign, maxpos, d, r;
    logic        n, z, v, c, cin, nz_from_r, is_byte;
    alu_word_t   res;
    // swab and sxt always work on the whole word
    is_byte   = byte_sel && (op != OP_SWAB) && (op != OP_SXT);
    mask      = is_byte ? LoByteMask : 16'hFFFF;
    sign      = is_byte ? 16'h0080 : 16'h8000;
    maxpos    = sign - 16'd1;
    d         = opnd & mask;
    r         = d;
    cin       = cc[FlagC];
    n         = 1'b0;
    z         = 1'b0;
    v         = 1'b0;
    c         = cin;
    nz_from_r = 1'b1;
    res.wb    = 1'b1;
    case (op)
      OP_CLR: begin
        r = '0;
        c = 1'b0;
      end
      OP_COM: begin
        r = ~d & mask;
        c = 1'b1;
      end
      OP_INC: begin
        v = (d == maxpos);
        r = (d + 16'd1) & mask;
      end
      OP_DEC: begin
        v = (d == sign);
        r = (d - 16'd1) & mask;
      end
      OP_NEG: begin
        r = (16'd0 - d) & mask;
        v = (r == sign);
        c = (r != '0);
      end
      OP_ADC: begin
        if (cin) begin
          v = (d == maxpos);
          c = (d == mask);
          r = (d + 16'd1) & mask;
        end else begin
          c = 1'b0;
        end
      end
      OP_SBC: begin
        v = (d == sign);
        if (cin) begin
          c = (d == '0);
          r = (d - 16'd1) & mask;
        end else begin
          c = 1'b0;
        end
      end
      OP_TST: begin
        c      = 1'b0;
        res.wb = 1'b0;
      end
      OP_ROR: begin
        r = (d >> 1) | (cin ? sign : 16'd0);
        c = d[0];
      end
      OP_ROL: begin
        r = ((d << 1) | {15'd0, cin}) & mask;
        c = |(d & sign);
      end
      OP_ASR: begin
        r = (d >> 1) | (d & sign);
        c = d[0];
      end
      OP_ASL: begin
        r = (d << 1) & mask;
        c = |(d & sign);
      end
      OP_SWAB: begin
        r         = {d[7:0], d[15:8]};
        n         = r[7];
        z         = (r[7:0] == 8'd0);
        c         = 1'b0;
        nz_from_r = 1'b0;
      end
      OP_SXT: begin
        n         = cc[FlagN];
        r         = n ? 16'hFFFF : 16'h0000;
        z         = !n;
        nz_from_r = 1'b0;
      end
      default: begin
        // unassigned codes pass the operand and flags through untouched
        res.value = opnd;
        res.wb    = 1'b0;
        res.flags = cc;
        return res;
      end
    endcase
    if (nz_from_r) begin
      n = |(r & sign);
      z = (r == '0);
    end
    if ((op == OP_ROR) || (op == OP_ROL) || (op == OP_ASR) || (op == OP_ASL)) begin
      v = n ^ c;
    end
    res.value        = r;
    res.flags[FlagN] = n;
    res.flags[FlagZ] = z;
    res.flags[FlagV] = v;
    res.flags[FlagC] = c;
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (predicted_q.size() == 0) begin
          $error("result word with nothing expected: result_value %h", result_value_o);
          mismatches++;
        end else begin
          want = predicted_q.pop_front();
          if (result_value_o !== want.value) begin
            $error("result_value: expected %h, got %h", want.value, result_value_o);
            mismatches++;
          end
          if (write_back_o !== want.wb) begin
            $error("write_back: expected %b, got %b", want.wb, write_back_o);
            mismatches++;
          end
          if (flags_out_o !== want.flags) begin
            $error("flags_out: expected %b, got %b", want.flags, flags_out_o);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_o) begin
        predicted_q.push_back(predict_alu_word(req_type_i, byte_mode_i, operand_i,
                                               flags_in_i));
      end
    end
    err_count_o <= mismatches;
    pending_o   <= predicted_q.size();
  end

endmodule

// ----- verif/testbench.sv -----
// Top of the single-operand ALU testbench: clock, reset, directed and random
// command words with idle phases, watchdog and verdict.
// Depends on soalu_pkg, single_operand_alu_with_flags and soalu_checker.
module testbench
  import soalu_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] OpReservedLo = 4'd14;
  localparam logic [3:0] OpReservedHi = 4'd15;
  localparam int         StallLimit   = 2000;
  localparam int         WordsPerPhase = 263;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start_i     = 1'b0;
  logic [3:0]  req_type_i  = '0;
  logic        byte_mode_i = 1'b0;
  logic [15:0] operand_i   = '0;
  logic [3:0]  flags_in_i  = '0;
  logic        busy_o;
  logic        done_o;
  logic [15:0] result_value_o;
  logic        write_back_o;
  logic [3:0]  flags_out_o;
  int          err_count;
  int          pending;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  single_operand_alu_with_flags dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .byte_mode_i    (byte_mode_i),
    .operand_i      (operand_i),
    .flags_in_i     (flags_in_i),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .write_back_o   (write_back_o),
    .flags_out_o    (flags_out_o)
  );

  soalu_checker alu_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .byte_mode_i    (byte_mode_i),
    .operand_i      (operand_i),
    .flags_in_i     (flags_in_i),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .write_back_o   (write_back_o),
    .flags_out_o    (flags_out_o),
    .err_count_o    (err_count),
    .pending_o      (pending)
  );

  function automatic logic [15:0] pick_operand();
    logic [15:0] corners [11] = '{16'h0000, 16'h0001, 16'h007F, 16'h0080, 16'h00FF,
                                  16'h7FFF, 16'h8000, 16'hFFFF, 16'hFF00, 16'hFF80,
                                  16'h0100};
    if ($urandom_range(0, 3) == 0) begin
      return corners[$urandom_range(0, 10)];
    end
    return 16'($urandom);
  endfunction

  // Present one word and hold it until the accepting edge.
  task automatic send_word(input logic [3:0] op, input logic bm, input logic [15:0] opnd,
                           input logic [3:0] cc);
    start_i     <= 1'b1;
    req_type_i  <= op;
    byte_mode_i <= bm;
    operand_i   <= opnd;
    flags_in_i  <= cc;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || done_o) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] corner_ops [4];
    int          idle_plan [4];
    int          idle_pct;
    logic [3:0]  op;

    corner_ops = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000};
    idle_plan  = '{0, 50, 0, 17};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every code once, including the unassigned ones, on corner operands
    for (int i = 0; i < 16; i++) begin
      send_word(4'(i), i[0], corner_ops[i % 4], 4'(i));
    end
    send_word(OP_INC, 1'b1, 16'h007F, 4'b0000);
    send_word(OP_DEC, 1'b1, 16'hAB80, 4'b0001);
    send_word(OP_NEG, 1'b0, 16'h8000, 4'b0000);
    send_word(OP_ADC, 1'b0, 16'hFFFF, 4'b0001);
    send_word(OP_SBC, 1'b0, 16'h0000, 4'b0001);
    send_word(OP_SBC, 1'b1, 16'h0080, 4'b0000);
    send_word(OP_SXT, 1'b1, 16'h1234, 4'b1000);
    send_word(OP_SWAB, 1'b1, 16'hFF00, 4'b1111);
    send_word(OP_ROR, 1'b1, 16'hFF01, 4'b0001);

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_plan[p];
      for (int k = 0; k < WordsPerPhase; k++) begin
        // drop start and scramble the fields while idle
        while ($urandom_range(0, 99) < idle_pct) begin
          start_i     <= 1'b0;
          req_type_i  <= 4'($urandom);
          byte_mode_i <= 1'($urandom);
          operand_i   <= 16'($urandom);
          flags_in_i  <= 4'($urandom);
          @(posedge clk_i);
        end
        if ($urandom_range(0, 15) == 0) op = 4'($urandom_range(OpReservedLo, OpReservedHi));
        else op = 4'($urandom_range(OP_CLR, OP_SXT));
        send_word(op, 1'($urandom), pick_operand(), 4'($urandom));
      end
    end
    start_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (err_count == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
